// File: rtl/core/pidc_pkg.sv
// Shared types, widths and codes for the three-mode PID controller.
package pidc_pkg;

  // Fraction bits of the Q-format gains
  localparam int unsigned GainFracBits = 8;
  // Number of past errors kept (older taps read as zero)
  localparam int unsigned HistDepth    = 5;
  // Storage slots for past errors, as used by the smoothed derivative
  localparam int unsigned HistSlots    = 5;
  // Extra scale of the smoothed derivative sum (divide by 16)
  localparam int unsigned SmoothShift  = 4;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned OpW     = ErrW + 4;
  localparam int unsigned ProdW   = GainW + OpW;
  localparam int unsigned AccW    = 48;
  localparam int unsigned SumW    = AccW + SmoothShift + 3;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam int unsigned ShiftFine   = GainFracBits;
  localparam int unsigned ShiftSmooth = GainFracBits + SmoothShift;

  // Control modes; the unused code behaves as positional
  localparam logic [ModeW-1:0] ModePos    = 2'd0;
  localparam logic [ModeW-1:0] ModeSmooth = 2'd1;
  localparam logic [ModeW-1:0] ModeInc    = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMode  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGainP = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGainI = 2'd2;
  localparam logic [CfgIdxW-1:0] RegGainD = 2'd3;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
  } cfg_t;

  // Products of one transaction
  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [ProdW-1:0] prod_p;
    logic signed [ProdW-1:0] prod_i;
    logic signed [ProdW-1:0] prod_d;
  } prod_t;

  // Terms left after the accumulator update
  typedef struct packed {
    logic [ModeW-1:0]        mode;
    logic signed [ProdW-1:0] prod_p;
    logic signed [ProdW-1:0] prod_d;
    logic signed [AccW-1:0]  acc;
  } acc_t;

  // Clamp a one-bit-wider sum into the signed accumulator range
  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [AccW:0] v);
    logic signed [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pidc_front.sv
// Input register, error history and gain products.
module pidc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidc_pkg::cfg_t                       cfg_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [pidc_pkg::SampleW-1:0]         position_i,
  input  logic [pidc_pkg::SampleW-1:0]         setpoint_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output pidc_pkg::prod_t                      prod_o
);

  logic                               a_valid_q;
  logic [pidc_pkg::SampleW-1:0]       position_q;
  logic [pidc_pkg::SampleW-1:0]       setpoint_q;
  logic                               b_valid_q;
  pidc_pkg::prod_t                    prod_q;
  pidc_pkg::prod_t                    prod_d;
  logic signed [pidc_pkg::ErrW-1:0]   hist_q [pidc_pkg::HistSlots];
  logic signed [pidc_pkg::ErrW-1:0]   err;
  logic signed [pidc_pkg::OpW-1:0]    ex, e1x, e2x, e3x, e4x, e5x;
  logic signed [pidc_pkg::OpW-1:0]    diff1, diff2, taps;
  logic signed [pidc_pkg::OpW-1:0]    op_p, op_d;
  logic                               a_stall;
  logic                               b_stall;

  // Stall a stage only when it holds a transaction the next one cannot take
  assign b_stall    = b_valid_q & stall_i;
  assign a_stall    = a_valid_q & b_stall;
  assign in_stall_o = a_stall;
  assign valid_o    = b_valid_q;
  assign prod_o     = prod_q;

  // Form the error and the derivative operands
  always_comb begin
    err   = $signed({1'b0, setpoint_q}) - $signed({1'b0, position_q});
    ex    = pidc_pkg::OpW'(err);
    e1x   = pidc_pkg::OpW'(hist_q[0]);
    e2x   = pidc_pkg::OpW'(hist_q[1]);
    e3x   = pidc_pkg::OpW'(hist_q[2]);
    e4x   = pidc_pkg::OpW'(hist_q[3]);
    e5x   = pidc_pkg::OpW'(hist_q[4]);
    diff1 = ex - e1x;
    diff2 = ex - (e1x <<< 1) + e2x;
    taps  = ex + (e1x <<< 1) + e1x + (e2x <<< 1) - (e3x <<< 1) - (e4x <<< 1) - e4x - e5x;
  end

  // Pick the operands for the selected mode and multiply
  always_comb begin
    unique case (cfg_i.mode)
      pidc_pkg::ModeInc: begin
        op_p = diff1;
        op_d = diff2;
      end
      pidc_pkg::ModeSmooth: begin
        op_p = ex;
        op_d = taps;
      end
      default: begin
        op_p = ex;
        op_d = diff1;
      end
    endcase
    prod_d.mode   = cfg_i.mode;
    prod_d.prod_p = pidc_pkg::ProdW'($signed(cfg_i.gain_p) * op_p);
    prod_d.prod_i = pidc_pkg::ProdW'($signed(cfg_i.gain_i) * ex);
    prod_d.prod_d = pidc_pkg::ProdW'($signed(cfg_i.gain_d) * op_d);
  end

  // Advance the stage valid bits and the error history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      for (int k = 0; k < pidc_pkg::HistSlots; k++) begin
        hist_q[k] <= '0;
      end
    end else begin
      if (!a_stall) begin
        a_valid_q <= in_valid_i;
      end
      if (!b_stall) begin
        b_valid_q <= a_valid_q;
        if (a_valid_q) begin
          hist_q[0] <= err;
          for (int k = 1; k < pidc_pkg::HistSlots; k++) begin
            hist_q[k] <= (k < pidc_pkg::HistDepth) ? hist_q[k-1] : '0;
          end
        end
      end
    end
  end

  // Hold payloads while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !a_stall) begin
      position_q <= position_i;
      setpoint_q <= setpoint_i;
    end
    if (a_valid_q && !b_stall) begin
      prod_q <= prod_d;
    end
  end

endmodule

// File: rtl/core/pidc_accum.sv
// Integral and incremental accumulators with saturation.
module pidc_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  pidc_pkg::prod_t  prod_i,
  output logic             valid_o,
  input  logic             stall_i,
  output pidc_pkg::acc_t   acc_o
);

  logic                              valid_q;
  pidc_pkg::acc_t                    acc_q;
  logic signed [pidc_pkg::AccW-1:0]  integral_q;
  logic signed [pidc_pkg::AccW-1:0]  total_q;
  logic signed [pidc_pkg::AccW:0]    int_sum;
  logic signed [pidc_pkg::AccW:0]    tot_sum;
  logic signed [pidc_pkg::AccW-1:0]  integral_d;
  logic signed [pidc_pkg::AccW-1:0]  total_d;
  logic                              is_inc;
  logic                              load;

  assign stall_o = valid_q & stall_i;
  assign load    = valid_i & ~stall_o;
  assign valid_o = valid_q;
  assign acc_o   = acc_q;
  assign is_inc  = (prod_i.mode == pidc_pkg::ModeInc);

  // Add this transaction's terms to each accumulator and clamp
  always_comb begin
    int_sum    = (pidc_pkg::AccW+1)'(integral_q)
               + (pidc_pkg::AccW+1)'($signed(prod_i.prod_i));
    tot_sum    = (pidc_pkg::AccW+1)'(total_q)
               + (pidc_pkg::AccW+1)'($signed(prod_i.prod_p))
               + (pidc_pkg::AccW+1)'($signed(prod_i.prod_i))
               + (pidc_pkg::AccW+1)'($signed(prod_i.prod_d));
    integral_d = pidc_pkg::sat_acc(int_sum);
    total_d    = pidc_pkg::sat_acc(tot_sum);
  end

  // Update only the accumulator that the mode uses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      integral_q <= '0;
      total_q    <= '0;
    end else begin
      if (!stall_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        if (is_inc) begin
          total_q <= total_d;
        end else begin
          integral_q <= integral_d;
        end
      end
    end
  end

  // Pass the remaining terms on
  always_ff @(posedge clk_i) begin
    if (load) begin
      acc_q.mode   <= prod_i.mode;
      acc_q.prod_p <= prod_i.prod_p;
      acc_q.prod_d <= prod_i.prod_d;
      acc_q.acc    <= is_inc ? total_d : integral_d;
    end
  end

endmodule

// File: rtl/core/pidc_out.sv
// Final sum, truncation toward zero, 32-bit saturation and result register.
module pidc_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  pidc_pkg::acc_t                      acc_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidc_pkg::DriveW-1:0]  drive_o,
  output logic                                clipped_o
);

  localparam logic signed [pidc_pkg::SumW-1:0] BiasFine =
    pidc_pkg::SumW'((64'sd1 <<< pidc_pkg::ShiftFine) - 64'sd1);
  localparam logic signed [pidc_pkg::SumW-1:0] BiasSmooth =
    pidc_pkg::SumW'((64'sd1 <<< pidc_pkg::ShiftSmooth) - 64'sd1);

  logic                                 d_valid_q;
  logic signed [pidc_pkg::SumW-1:0]     sum_q;
  logic                                 smooth_q;
  logic                                 o_valid_q;
  logic signed [pidc_pkg::DriveW-1:0]   drive_q;
  logic                                 clipped_q;
  logic signed [pidc_pkg::SumW-1:0]     p_x, a_x, d_x;
  logic signed [pidc_pkg::SumW-1:0]     sum_d;
  logic signed [pidc_pkg::SumW-1:0]     bias;
  logic signed [pidc_pkg::SumW-1:0]     biased;
  logic signed [pidc_pkg::SumW-1:0]     quo;
  logic                                 in_range;
  logic signed [pidc_pkg::DriveW-1:0]   drive_d;
  logic                                 d_stall;
  logic                                 o_stall;

  assign o_stall     = o_valid_q & out_stall_i;
  assign d_stall     = d_valid_q & o_stall;
  assign stall_o     = d_stall;
  assign out_valid_o = o_valid_q;
  assign drive_o     = drive_q;
  assign clipped_o   = clipped_q;

  // Combine the terms at the scale of the selected mode
  always_comb begin
    p_x = pidc_pkg::SumW'($signed(acc_i.prod_p));
    a_x = pidc_pkg::SumW'($signed(acc_i.acc));
    d_x = pidc_pkg::SumW'($signed(acc_i.prod_d));
    unique case (acc_i.mode)
      pidc_pkg::ModeInc:    sum_d = a_x;
      pidc_pkg::ModeSmooth: sum_d = ((p_x + a_x) <<< pidc_pkg::SmoothShift) + d_x;
      default:              sum_d = p_x + a_x + d_x;
    endcase
  end

  // Drop the fraction toward zero and clamp to 32 bits
  always_comb begin
    if (sum_q[pidc_pkg::SumW-1]) begin
      bias = smooth_q ? BiasSmooth : BiasFine;
    end else begin
      bias = '0;
    end
    biased   = sum_q + bias;
    quo      = smooth_q ? (biased >>> pidc_pkg::ShiftSmooth)
                        : (biased >>> pidc_pkg::ShiftFine);
    in_range = (&quo[pidc_pkg::SumW-1:pidc_pkg::DriveW-1])
             | ~(|quo[pidc_pkg::SumW-1:pidc_pkg::DriveW-1]);
    if (in_range) begin
      drive_d = quo[pidc_pkg::DriveW-1:0];
    end else if (quo[pidc_pkg::SumW-1]) begin
      drive_d = {1'b1, {(pidc_pkg::DriveW-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(pidc_pkg::DriveW-1){1'b1}}};
    end
  end

  // Advance stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (!d_stall) begin
        d_valid_q <= valid_i;
      end
      if (!o_stall) begin
        o_valid_q <= d_valid_q;
      end
    end
  end

  // Hold payloads while stalled
  always_ff @(posedge clk_i) begin
    if (valid_i && !d_stall) begin
      sum_q    <= sum_d;
      smooth_q <= (acc_i.mode == pidc_pkg::ModeSmooth);
    end
    if (d_valid_q && !o_stall) begin
      drive_q   <= drive_d;
      clipped_q <= ~in_range;
    end
  end

endmodule

// File: rtl/core/pid_controller_three_mode.sv
// Three-mode PID controller: configuration registers and pipeline.
// Each transaction carries a position and a setpoint and yields one drive
// value with a saturation flag. The pipeline takes one transaction per
// clock while the output side does not stall. Registers hold in turn the
// input sample, gain products, accumulator result, final sum and drive. The
// rate is set by the accumulator stage, which adds and clamps the integral
// or incremental total. Mode 0 is positional PID, mode 1 positional with a
// six-tap smoothed derivative, mode 2 incremental; mode 3 acts as mode 0.
// Write configuration only while no transaction is in flight.
module pid_controller_three_mode (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pidc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pidc_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pidc_pkg::SampleW-1:0]        position_i,
  input  logic [pidc_pkg::SampleW-1:0]        setpoint_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidc_pkg::DriveW-1:0]  drive_o,
  output logic                                clipped_o
);

  pidc_pkg::cfg_t   cfg_q;
  pidc_pkg::prod_t  prod;
  pidc_pkg::acc_t   acc;
  logic             prod_valid;
  logic             prod_stall;
  logic             acc_valid;
  logic             acc_stall;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pidc_pkg::RegMode:  cfg_q.mode   <= cfg_wdata_i[pidc_pkg::ModeW-1:0];
        pidc_pkg::RegGainP: cfg_q.gain_p <= cfg_wdata_i;
        pidc_pkg::RegGainI: cfg_q.gain_i <= cfg_wdata_i;
        pidc_pkg::RegGainD: cfg_q.gain_d <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  pidc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .position_i (position_i),
    .setpoint_i (setpoint_i),
    .valid_o    (prod_valid),
    .stall_i    (prod_stall),
    .prod_o     (prod)
  );

  pidc_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .stall_o (prod_stall),
    .prod_i  (prod),
    .valid_o (acc_valid),
    .stall_i (acc_stall),
    .acc_o   (acc)
  );

  pidc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (acc_valid),
    .stall_o     (acc_stall),
    .acc_i       (acc),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .clipped_o   (clipped_o)
  );

endmodule

// File: rtl/core/pidc_checker.sv
// Port-level checks for the PID controller, bound to the top level.
module pidc_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [pidc_pkg::DriveW-1:0]  drive_i,
  input  logic                                clipped_i
);

  localparam logic [pidc_pkg::DriveW-1:0] DriveMax = {1'b0, {(pidc_pkg::DriveW-1){1'b1}}};
  localparam logic [pidc_pkg::DriveW-1:0] DriveMin = {1'b1, {(pidc_pkg::DriveW-1){1'b0}}};

  // A stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(drive_i) && $stable(clipped_i))
    else $error("stalled result changed");

  // A clipped result sits at one of the rails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clipped_i |-> drive_i == DriveMax || drive_i == DriveMin)
    else $error("clipped result not at a rail");

  // Input back-pressure comes only from a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || !out_stall_i |-> !in_stall_i)
    else $error("input stalled while output is free");

  // A valid result carries known values
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown({drive_i, clipped_i}))
    else $error("valid result has unknown bits");

endmodule

bind pid_controller_three_mode pidc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_i     (drive_o),
  .clipped_i   (clipped_o)
);

// File: dv/pid_controller_three_mode_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-mode PID controller: predicts each drive value and compares.
module pid_controller_three_mode_test;

  localparam int unsigned RandomItems = 620;
  localparam int unsigned SoakItems   = 300;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax   = 10;

  // Unnamed mode code, expected to act as positional
  localparam logic [pidc_pkg::ModeW-1:0] ModeSpare = 2'd3;

  localparam longint AccMax   = (64'sd1 <<< (pidc_pkg::AccW - 1)) - 1;
  localparam longint AccMin   = -AccMax - 1;
  localparam longint DriveMax = 64'sd2147483647;
  localparam longint DriveMin = -DriveMax - 1;

  typedef struct packed {
    logic signed [pidc_pkg::DriveW-1:0] drive;
    logic                               clipped;
  } drive_result_t;

  // Predict drive values and check them against the block
  class pid_drive_predictor;
    logic [pidc_pkg::ModeW-1:0]        mode   = '0;
    logic signed [pidc_pkg::GainW-1:0] gain_p = '0;
    logic signed [pidc_pkg::GainW-1:0] gain_i = '0;
    logic signed [pidc_pkg::GainW-1:0] gain_d = '0;
    longint err_hist[pidc_pkg::HistSlots];
    longint integ_sum = 0;
    longint inc_total = 0;
    drive_result_t pending_drives[$];
    int unsigned mismatches = 0;
    int unsigned accepted   = 0;
    int unsigned clips      = 0;
    int unsigned acc_clamps = 0;

    function new();
      foreach (err_hist[k]) err_hist[k] = 0;
    endfunction

    function void write_reg(logic [pidc_pkg::CfgIdxW-1:0] idx, logic [pidc_pkg::CfgW-1:0] data);
      case (idx)
        pidc_pkg::RegMode:  mode   = data[pidc_pkg::ModeW-1:0];
        pidc_pkg::RegGainP: gain_p = data;
        pidc_pkg::RegGainI: gain_i = data;
        pidc_pkg::RegGainD: gain_d = data;
        default: ;
      endcase
    endfunction

    function longint clamp_acc(longint v);
      if (v > AccMax) begin
        acc_clamps++;
        return AccMax;
      end
      if (v < AccMin) begin
        acc_clamps++;
        return AccMin;
      end
      return v;
    endfunction

    // Past error k, 1 being the latest; taps beyond the kept depth read zero
    function longint past_error(int unsigned k);
      if (k > pidc_pkg::HistDepth) return 0;
      return err_hist[k-1];
    endfunction

    function int pending();
      return pending_drives.size();
    endfunction

    // Work out the result of one accepted transaction and queue it
    function void take_sample(logic [pidc_pkg::SampleW-1:0] pos,
                              logic [pidc_pkg::SampleW-1:0] tgt);
      longint e, e1, e2, gp, gi, gd, taps, sum, drive;
      int unsigned shift;
      drive_result_t r;
      gp = longint'(gain_p);
      gi = longint'(gain_i);
      gd = longint'(gain_d);
      e = longint'(tgt);
      e = e - longint'(pos);
      e1 = past_error(1);
      e2 = past_error(2);
      shift = pidc_pkg::ShiftFine;
      if (mode == pidc_pkg::ModeInc) begin
        inc_total = clamp_acc(inc_total + gp * (e - e1) + gi * e + gd * (e - 2 * e1 + e2));
        sum = inc_total;
      end else if (mode == pidc_pkg::ModeSmooth) begin
        taps = e + 3 * e1 + 2 * e2 - 2 * past_error(3) - 3 * past_error(4) - past_error(5);
        integ_sum = clamp_acc(integ_sum + gi * e);
        sum = ((gp * e + integ_sum) <<< pidc_pkg::SmoothShift) + gd * taps;
        shift = pidc_pkg::ShiftSmooth;
      end else begin
        integ_sum = clamp_acc(integ_sum + gi * e);
        sum = gp * e + integ_sum + gd * (e - e1);
      end
      // Division truncates toward zero
      drive = sum / (64'sd1 <<< shift);
      r.clipped = 1'b0;
      if (drive > DriveMax) begin
        drive = DriveMax;
        r.clipped = 1'b1;
      end
      if (drive < DriveMin) begin
        drive = DriveMin;
        r.clipped = 1'b1;
      end
      if (r.clipped) clips++;
      r.drive = drive[pidc_pkg::DriveW-1:0];
      for (int k = pidc_pkg::HistSlots - 1; k > 0; k--) begin
        err_hist[k] = (k < pidc_pkg::HistDepth) ? err_hist[k-1] : 0;
      end
      err_hist[0] = e;
      accepted++;
      pending_drives.push_back(r);
    endfunction

    function void flag(string what, logic signed [63:0] want, logic signed [63:0] got);
      mismatches++;
      if (mismatches <= ReportMax) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void compare_drive(logic signed [pidc_pkg::DriveW-1:0] drive, logic clipped);
      drive_result_t want;
      if (pending_drives.size() == 0) begin
        flag("unrequested drive", 0, drive);
        return;
      end
      want = pending_drives.pop_front();
      if (drive !== want.drive) flag("drive", want.drive, drive);
      if (clipped !== want.clipped) flag("clipped", want.clipped, clipped);
    endfunction
  endclass

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [pidc_pkg::CfgIdxW-1:0]        cfg_index_i;
  logic [pidc_pkg::CfgW-1:0]           cfg_wdata_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [pidc_pkg::SampleW-1:0]        position_i;
  logic [pidc_pkg::SampleW-1:0]        setpoint_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [pidc_pkg::DriveW-1:0]  drive_o;
  logic                                clipped_o;

  pid_drive_predictor drive_calc;
  int unsigned send_idle_pct = 31;
  int unsigned recv_idle_pct = 50;
  int unsigned quiet_cycles  = 0;
  int unsigned settings      = 0;

  pid_controller_three_mode u_dut (.*);

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the output side at random
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check results and guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) drive_calc.compare_drive(drive_o, clipped_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, drive_calc.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Present one transaction, idling first at random; return at the falling edge after it
  task automatic send_sample(input logic [pidc_pkg::SampleW-1:0] pos,
                             input logic [pidc_pkg::SampleW-1:0] tgt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      position_i <= 16'($urandom);
      setpoint_i <= 16'($urandom);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    setpoint_i <= tgt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    drive_calc.take_sample(pos, tgt);
    @(negedge clk_i);
  endtask

  // Hold off input until every predicted result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (drive_calc.pending() != 0) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [pidc_pkg::CfgIdxW-1:0] idx,
                         input logic [pidc_pkg::CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    drive_calc.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Drain the pipeline, then load all four registers
  task automatic retune(input logic [pidc_pkg::CfgW-1:0] mode_word,
                        input logic [pidc_pkg::CfgW-1:0] gp,
                        input logic [pidc_pkg::CfgW-1:0] gi,
                        input logic [pidc_pkg::CfgW-1:0] gd);
    wait_drained();
    put_reg(pidc_pkg::RegMode, mode_word);
    put_reg(pidc_pkg::RegGainP, gp);
    put_reg(pidc_pkg::RegGainI, gi);
    put_reg(pidc_pkg::RegGainD, gd);
    cfg_we_i <= 1'b0;
    settings++;
    @(negedge clk_i);
  endtask

  function automatic logic [pidc_pkg::GainW-1:0] pick_gain();
    logic [pidc_pkg::GainW-1:0] g;
    case ($urandom_range(3))
      0: g = 16'($urandom);
      1: begin
        case ($urandom_range(2))
          0: g = 16'h7FFF;
          1: g = 16'h8000;
          default: g = 16'h0000;
        endcase
      end
      2: begin
        g = 16'($urandom_range(1023));
        if ($urandom_range(1)) g = -g;
      end
      default: g = 16'd256 + 16'($urandom_range(63)) - 16'd32;
    endcase
    return g;
  endfunction

  function automatic logic [pidc_pkg::SampleW-1:0] pick_rail();
    case ($urandom_range(2))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Styles: uniform, rails, tracking a setpoint, steady large error
  task automatic pick_sample(input int unsigned style, input logic [15:0] target,
                             output logic [15:0] pos, output logic [15:0] tgt);
    case (style)
      0: begin
        pos = 16'($urandom);
        tgt = 16'($urandom);
      end
      1: begin
        pos = pick_rail();
        tgt = pick_rail();
      end
      2: begin
        tgt = target;
        pos = target + 16'($urandom_range(63)) - 16'd32;
      end
      default: begin
        tgt = target;
        pos = ~target ^ 16'($urandom_range(255));
      end
    endcase
  endtask

  // Ramp an accumulator with a long run of near-full error until the drive clips, then back off
  task automatic soak(input logic [pidc_pkg::CfgW-1:0] mode_word, input bit push_up);
    logic [pidc_pkg::SampleW-1:0] lo, hi;
    retune(mode_word, pick_gain(), 16'h7FFF, pick_gain());
    repeat (SoakItems) begin
      lo = 16'($urandom_range(15));
      hi = 16'hFFFF - 16'($urandom_range(15));
      if (push_up) send_sample(lo, hi);
      else send_sample(hi, lo);
    end
    repeat (40) begin
      lo = 16'($urandom_range(255));
      hi = 16'hFFFF - 16'($urandom_range(255));
      if (push_up) send_sample(hi, lo);
      else send_sample(lo, hi);
    end
  endtask

  initial begin
    logic [pidc_pkg::SampleW-1:0] pos, tgt, seg_target;
    logic [pidc_pkg::CfgW-1:0]    mode_word;
    int unsigned random_sent, seg_len, style;
    drive_calc  = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    position_i  = '0;
    setpoint_i  = '0;
    out_stall_i = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset settings, then each mode at the gain and sample extremes
    send_sample(16'hFFFF, 16'hFFFF);
    retune({14'd0, pidc_pkg::ModePos}, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'h0000);
    retune({14'd0, pidc_pkg::ModeSmooth}, 16'h8000, 16'h7FFF, 16'h8000);
    repeat (3) begin
      send_sample(16'h0000, 16'hFFFF);
      send_sample(16'hFFFF, 16'h0000);
    end
    retune({14'd0, pidc_pkg::ModeInc}, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'h8000, 16'h7FFF);
    // Spare mode code with junk in the upper write bits; tiny negative terms truncate to zero
    retune({14'h3FFF, ModeSpare}, 16'h0001, 16'hFFFF, 16'h0100);
    send_sample(16'h0001, 16'h0000);
    send_sample(16'h0000, 16'h0001);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);

    // Random segments, each under fresh settings
    random_sent = 0;
    while (random_sent < RandomItems) begin
      if (random_sent >= 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_sent >= RandomItems / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 31;
      end
      mode_word = 16'($urandom_range(3));
      if ($urandom_range(1)) mode_word[15:2] = 14'($urandom);
      retune(mode_word, pick_gain(), pick_gain(), pick_gain());
      seg_len    = $urandom_range(10, 60);
      style      = $urandom_range(3);
      seg_target = 16'($urandom);
      repeat (seg_len) begin
        pick_sample(style, seg_target, pos, tgt);
        send_sample(pos, tgt);
        if ($urandom_range(49) == 0) wait_drained();
      end
      random_sent += seg_len;
    end

    // Ramp both accumulators, the incremental total upward and the integral downward
    soak({14'd0, pidc_pkg::ModeInc}, 1'b1);
    soak({14'd0, pidc_pkg::ModePos}, 1'b0);

    // Let the last results land
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);

    if (drive_calc.pending() != 0) begin
      $display("%0d predicted results never arrived", drive_calc.pending());
    end
    $display("Run covered %0d transactions under %0d register settings, all four mode codes,",
             drive_calc.accepted, settings);
    $display("with %0d clipped drive values and %0d accumulator clamps; %0d mismatches.",
             drive_calc.clips, drive_calc.acc_clamps, drive_calc.mismatches);
    if (drive_calc.mismatches == 0 && drive_calc.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: pid_controller_three_mode.f
rtl/core/pidc_pkg.sv
rtl/core/pidc_front.sv
rtl/core/pidc_accum.sv
rtl/core/pidc_out.sv
rtl/core/pid_controller_three_mode.sv
rtl/core/pidc_checker.sv
dv/pid_controller_three_mode_test.sv
